>>> hw/rtl/olint_pkg.sv
// types and constants for the orbit lagrange interpolator
// no dependencies
package olint_pkg;

   localparam int MAX_NODES = 16;
   localparam int NODE_W    = $clog2(MAX_NODES);
   localparam int CNT_W     = NODE_W + 1;
   localparam int VAL_W     = 48;
   localparam int VALS      = 6;
   localparam int FRAC_W    = 20;
   localparam int WFRAC_W   = 40;
   localparam int WMAG_W    = 63;
   localparam int DIFF_W    = VAL_W + 1;
   localparam int PROD_W    = WMAG_W + DIFF_W;
   localparam int REM_W     = DIFF_W + 1;
   localparam int ACC_W     = PROD_W + NODE_W + 1;
   localparam int ROW_W     = VAL_W * VALS;
   localparam int STEP_W    = $clog2(PROD_W + 1);

   localparam logic [WMAG_W-1:0] W_ONE = WMAG_W'(64'd1 << WFRAC_W);
   localparam logic [WMAG_W-1:0] W_LIM = WMAG_W'(64'd1 << 62);

   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   typedef struct packed {
      logic                    kind;
      logic [3:0]              slot;
      logic signed [VAL_W-1:0] sample_time;
      logic signed [VAL_W-1:0] pos_x;
      logic signed [VAL_W-1:0] pos_y;
      logic signed [VAL_W-1:0] pos_z;
      logic signed [VAL_W-1:0] vel_x;
      logic signed [VAL_W-1:0] vel_y;
      logic signed [VAL_W-1:0] vel_z;
   } req_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] out_time;
      logic signed [VAL_W-1:0] out_pos_x;
      logic signed [VAL_W-1:0] out_pos_y;
      logic signed [VAL_W-1:0] out_pos_z;
      logic signed [VAL_W-1:0] out_vel_x;
      logic signed [VAL_W-1:0] out_vel_y;
      logic signed [VAL_W-1:0] out_vel_z;
   } rsp_type;

endpackage

>>> hw/rtl/orbit_lagrange_interpolator.sv
// orbit lagrange interpolator: node tables in two small synchronous memories, serial datapath
// depends on olint_pkg
// A load item writes one node. A query walks the n active nodes. For each node i and each
// other node j there are two fetch states, one 49-step shift-add multiply, one 112-step
// restoring division and one rounding state, which scale the weight. Then six 49-step
// multiplies accumulate the weighted values, and S_FIN rounds and saturates the six sums.
// One shared bit-serial multiply/divide unit does all of this work in turn.
// The result sits in an output register, so a load can be taken while it waits.
module orbit_lagrange_interpolator (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  olint_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output olint_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [4:0]        csr_data
);
   import olint_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_TI   = 4'd1;
   localparam logic [3:0] S_TIW  = 4'd2;
   localparam logic [3:0] S_TJ   = 4'd3;
   localparam logic [3:0] S_TJW  = 4'd4;
   localparam logic [3:0] S_MUL  = 4'd5;
   localparam logic [3:0] S_DIV  = 4'd6;
   localparam logic [3:0] S_RND  = 4'd7;
   localparam logic [3:0] S_VAL  = 4'd8;
   localparam logic [3:0] S_VMUL = 4'd9;
   localparam logic [3:0] S_ACC  = 4'd10;
   localparam logic [3:0] S_FIN  = 4'd11;
   localparam logic [3:0] S_SEND = 4'd12;

   logic [VAL_W-1:0] time_mem [MAX_NODES];
   logic [ROW_W-1:0] row_mem  [MAX_NODES];
   logic [VAL_W-1:0] time_rd_ff;
   logic [ROW_W-1:0] row_rd_ff;
   logic [NODE_W-1:0] rd_addr;
   logic mem_we;

   logic [3:0] state_ff, state_in;
   logic [4:0] count_ff;
   logic [CNT_W-1:0] n_eff;
   logic [CNT_W-1:0] i_ff, i_in, j_ff, j_in;
   logic [2:0] k_ff, k_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic signed [VAL_W-1:0] t_ff, t_in, ti_ff, ti_in;
   logic [WMAG_W-1:0] mw_ff, mw_in;
   logic wneg_ff, wneg_in, fneg_ff, fneg_in;
   logic [DIFF_W-1:0] den_ff, den_in;
   logic [PROD_W-1:0] p_ff, p_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic signed [ACC_W-1:0] acc_ff [VALS];
   logic signed [ACC_W-1:0] acc_in [VALS];
   logic [VAL_W-1:0] res_ff [VALS];
   logic [VAL_W-1:0] res_in [VALS];
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic signed [DIFF_W-1:0] num_s, den_s;
   logic [WMAG_W:0] mul_sum;
   logic [REM_W-1:0] trial;
   logic [REM_W:0] trial_diff;
   logic [WMAG_W-1:0] q_rnd;
   logic [VAL_W-1:0] vcur;
   logic [VAL_W-1:0] vabs;
   logic signed [ACC_W-1:0] prod_s;
   logic signed [ACC_W-1:0] rsum;
   logic signed [ACC_W-WFRAC_W-1:0] rsh;
   logic [VAL_W-1:0] rsat;

   assign n_eff = (count_ff == 5'd0) ? CNT_W'(1) :
                  ({1'b0, count_ff} > 6'(MAX_NODES)) ? CNT_W'(MAX_NODES) : CNT_W'(count_ff);
   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign mem_we = req_valid && req_ready && (req_data.kind == KIND_LOAD) &&
                   ({1'b0, req_data.slot} < 5'(MAX_NODES));

   always_ff @(posedge clock) begin
      if (mem_we) begin
         time_mem[NODE_W'(req_data.slot)] <= req_data.sample_time;
         row_mem[NODE_W'(req_data.slot)]  <= {req_data.vel_z, req_data.vel_y, req_data.vel_x,
                                             req_data.pos_z, req_data.pos_y, req_data.pos_x};
      end
      time_rd_ff <= time_mem[rd_addr];
      row_rd_ff  <= row_mem[rd_addr];
   end

   always_comb begin
      rd_addr = (state_ff == S_TJ) ? j_ff[NODE_W-1:0] : i_ff[NODE_W-1:0];
      num_s = DIFF_W'(t_ff) - DIFF_W'(signed'(time_rd_ff));
      den_s = DIFF_W'(ti_ff) - DIFF_W'(signed'(time_rd_ff));
      mul_sum = {1'b0, p_ff[PROD_W-1:DIFF_W]} + (p_ff[0] ? {1'b0, mw_ff} : '0);
      trial = {rem_ff[REM_W-2:0], p_ff[PROD_W-1]};
      trial_diff = {1'b0, trial} - {2'b00, den_ff};
      q_rnd = p_ff[WMAG_W-1:0] + WMAG_W'(({rem_ff, 1'b0} >= {2'b00, den_ff}) ? 1 : 0);
      vcur = row_ff[k_ff*VAL_W +: VAL_W];
      vabs = vcur[VAL_W-1] ? VAL_W'(-vcur) : vcur;
      prod_s = fneg_ff ? -ACC_W'(p_ff) : ACC_W'(p_ff);
      rsum = acc_ff[k_ff] + ACC_W'(64'd1 << (WFRAC_W - 1));
      rsh = rsum[ACC_W-1:WFRAC_W];
      if (rsh > (ACC_W-WFRAC_W)'(64'sh7FFFFFFFFFFF)) begin
         rsat = {1'b0, {(VAL_W-1){1'b1}}};
      end else if (rsh < -(ACC_W-WFRAC_W)'(64'sh800000000000)) begin
         rsat = {1'b1, {(VAL_W-1){1'b0}}};
      end else begin
         rsat = rsh[VAL_W-1:0];
      end

      state_in = state_ff;
      i_in = i_ff;
      j_in = j_ff;
      k_in = k_ff;
      step_in = step_ff;
      t_in = t_ff;
      ti_in = ti_ff;
      mw_in = mw_ff;
      wneg_in = wneg_ff;
      fneg_in = fneg_ff;
      den_in = den_ff;
      p_in = p_ff;
      rem_in = rem_ff;
      row_in = row_ff;
      acc_in = acc_ff;
      res_in = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in = rsp_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_data.kind == KIND_QUERY) begin
               t_in = req_data.sample_time;
               i_in = '0;
               for (int v = 0; v < VALS; v++) acc_in[v] = '0;
               state_in = S_TI;
            end
         end
         S_TI: state_in = S_TIW;
         S_TIW: begin
            ti_in = signed'(time_rd_ff);
            row_in = row_rd_ff;
            mw_in = W_ONE;
            wneg_in = 1'b0;
            j_in = '0;
            state_in = S_TJ;
         end
         S_TJ: begin
            if (j_ff == n_eff) begin
               k_in = '0;
               state_in = S_VAL;
            end else if (j_ff == i_ff) begin
               j_in = j_ff + 1'b1;
            end else begin
               state_in = S_TJW;
            end
         end
         S_TJW: begin
            if (den_s == '0) begin
               j_in = j_ff + 1'b1;
               state_in = S_TJ;
            end else begin
               den_in = den_s[DIFF_W-1] ? DIFF_W'(-den_s) : DIFF_W'(den_s);
               p_in = {{WMAG_W{1'b0}}, (num_s[DIFF_W-1] ? DIFF_W'(-num_s) : DIFF_W'(num_s))};
               fneg_in = num_s[DIFF_W-1] ^ den_s[DIFF_W-1];
               step_in = '0;
               state_in = S_MUL;
            end
         end
         S_MUL, S_VMUL: begin
            p_in = {mul_sum, p_ff[DIFF_W-1:1]};
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(DIFF_W - 1)) begin
               step_in = '0;
               rem_in = '0;
               state_in = (state_ff == S_MUL) ? S_DIV : S_ACC;
            end
         end
         S_DIV: begin
            if (trial_diff[REM_W]) begin
               rem_in = trial;
               p_in = {p_ff[PROD_W-2:0], 1'b0};
            end else begin
               rem_in = trial_diff[REM_W-1:0];
               p_in = {p_ff[PROD_W-2:0], 1'b1};
            end
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(PROD_W - 1)) state_in = S_RND;
         end
         S_RND: begin
            if (p_ff[PROD_W-1:WMAG_W-1] != '0) mw_in = W_LIM;
            else mw_in = q_rnd;
            wneg_in = wneg_ff ^ fneg_ff;
            j_in = j_ff + 1'b1;
            state_in = S_TJ;
         end
         S_VAL: begin
            p_in = {{WMAG_W{1'b0}}, 1'b0, vabs};
            fneg_in = wneg_ff ^ vcur[VAL_W-1];
            step_in = '0;
            state_in = S_VMUL;
         end
         S_ACC: begin
            acc_in[k_ff] = acc_ff[k_ff] + prod_s;
            k_in = k_ff + 1'b1;
            state_in = S_VAL;
            if (k_ff == 3'(VALS - 1)) begin
               i_in = i_ff + 1'b1;
               k_in = '0;
               state_in = (i_ff + 1'b1 == n_eff) ? S_FIN : S_TI;
            end
         end
         S_FIN: begin
            res_in[k_ff] = rsat;
            k_in = k_ff + 1'b1;
            if (k_ff == 3'(VALS - 1)) state_in = S_SEND;
         end
         S_SEND: begin
            if (!rsp_valid_ff) begin
               rsp_valid_in = 1'b1;
               rsp_in.out_time = t_ff;
               rsp_in.out_pos_x = res_ff[0];
               rsp_in.out_pos_y = res_ff[1];
               rsp_in.out_pos_z = res_ff[2];
               rsp_in.out_vel_x = res_ff[3];
               rsp_in.out_vel_y = res_ff[4];
               rsp_in.out_vel_z = res_ff[5];
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= 5'd1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) count_ff <= csr_data;
      end
      i_ff <= i_in;
      j_ff <= j_in;
      k_ff <= k_in;
      step_ff <= step_in;
      t_ff <= t_in;
      ti_ff <= ti_in;
      mw_ff <= mw_in;
      wneg_ff <= wneg_in;
      fneg_ff <= fneg_in;
      den_ff <= den_in;
      p_ff <= p_in;
      rem_ff <= rem_in;
      row_ff <= row_in;
      acc_ff <= acc_in;
      res_ff <= res_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   a_rsp_from_send: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_SEND)
      else $error("item issued outside send state");
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> state_ff == S_IDLE)
      else $error("table write during query");
   a_weight_lim: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_TJ) |-> mw_ff <= W_LIM)
      else $error("weight above limit");
   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MUL || state_ff == S_VMUL) |-> step_ff < STEP_W'(DIFF_W))
      else $error("multiply step overrun");

endmodule

>>> tb/olint_checker.sv
// checker for the orbit lagrange interpolator: watches all three channels, predicts and compares
// keeps its own node tables and node count; depends on olint_pkg
`timescale 1ns / 100ps
module olint_checker (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  olint_pkg::req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  olint_pkg::rsp_type rsp_data,
   input  logic    csr_valid,
   input  logic    csr_ready,
   input  logic [4:0] csr_data,
   output int      fail_count,
   output int      pending
);
   import olint_pkg::*;

   logic signed [VAL_W-1:0] node_time [MAX_NODES];
   logic signed [VAL_W-1:0] node_val [MAX_NODES][VALS];
   logic [4:0] node_count;
   rsp_type expected_fixes[$];

   function automatic logic signed [VAL_W-1:0] round_clip(logic signed [127:0] acc);
      logic signed [127:0] s;
      s = (acc + (128'sd1 <<< 39)) >>> 40;
      if (s > 128'sd140737488355327) return 48'sh7FFF_FFFF_FFFF;
      if (s < -128'sd140737488355328) return 48'sh8000_0000_0000;
      return s[VAL_W-1:0];
   endfunction

   function automatic rsp_type interpolate_fix(logic signed [VAL_W-1:0] t);
      int n;
      logic [63:0] mw, num, den, vabs;
      logic signed [63:0] ti, tj, dn, dd, v;
      logic [127:0] p, q, rem;
      logic signed [127:0] acc [VALS];
      logic signed [127:0] prod;
      logic wneg, nneg, dneg, vneg;
      rsp_type r;
      n = (node_count == 0) ? 1 : (node_count > MAX_NODES) ? MAX_NODES : int'(node_count);
      for (int k = 0; k < VALS; k++) acc[k] = '0;
      for (int i = 0; i < n; i++) begin
         ti = 64'(node_time[i]);
         mw = 64'(W_ONE);
         wneg = 1'b0;
         for (int j = 0; j < n; j++) begin
            if (j == i) continue;
            tj = 64'(node_time[j]);
            dn = 64'(t) - tj;
            dd = ti - tj;
            if (dd == 0) continue;
            nneg = dn[63];
            dneg = dd[63];
            num = nneg ? -dn : dn;
            den = dneg ? -dd : dd;
            p = 128'(mw) * 128'(num);
            q = p / 128'(den);
            rem = p % 128'(den);
            if (q >= 128'(W_LIM)) mw = 64'(W_LIM);
            else mw = q[63:0] + ((rem * 2 >= 128'(den)) ? 64'd1 : 64'd0);
            wneg = wneg ^ nneg ^ dneg;
         end
         for (int k = 0; k < VALS; k++) begin
            v = 64'(node_val[i][k]);
            vneg = v[63];
            vabs = vneg ? -v : v;
            prod = 128'(mw) * 128'(vabs);
            acc[k] = (wneg != vneg) ? acc[k] - prod : acc[k] + prod;
         end
      end
      r.out_time  = t;
      r.out_pos_x = round_clip(acc[0]);
      r.out_pos_y = round_clip(acc[1]);
      r.out_pos_z = round_clip(acc[2]);
      r.out_vel_x = round_clip(acc[3]);
      r.out_vel_y = round_clip(acc[4]);
      r.out_vel_z = round_clip(acc[5]);
      return r;
   endfunction

   string field_name [7] = '{"out_time", "out_pos_x", "out_pos_y", "out_pos_z",
                             "out_vel_x", "out_vel_y", "out_vel_z"};

   always @(posedge clock) begin
      rsp_type want;
      logic [VAL_W-1:0] a, b;
      bit bad;
      if (reset) begin
         node_count <= 5'd1;
         expected_fixes.delete();
         fail_count <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_fixes.size() == 0) begin
               if (fail_count < 10) $display("unexpected result item %h", rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_fixes.pop_front();
               bad = 1'b0;
               for (int f = 0; f < 7; f++) begin
                  a = want[(6-f)*VAL_W +: VAL_W];
                  b = rsp_data[(6-f)*VAL_W +: VAL_W];
                  if (a !== b) begin
                     bad = 1'b1;
                     if (fail_count < 10)
                        $display("mismatch %s: expected %h got %h", field_name[f], a, b);
                  end
               end
               if (bad) fail_count <= fail_count + 1;
            end
         end
         if (csr_valid && csr_ready) node_count <= csr_data;
         if (req_valid && req_ready) begin
            if (req_data.kind == KIND_LOAD) begin
               node_time[req_data.slot]   = req_data.sample_time;
               node_val[req_data.slot][0] = req_data.pos_x;
               node_val[req_data.slot][1] = req_data.pos_y;
               node_val[req_data.slot][2] = req_data.pos_z;
               node_val[req_data.slot][3] = req_data.vel_x;
               node_val[req_data.slot][4] = req_data.vel_y;
               node_val[req_data.slot][5] = req_data.vel_z;
            end else begin
               expected_fixes.push_back(interpolate_fix(req_data.sample_time));
            end
         end
      end
   end

   assign pending = expected_fixes.size();

endmodule

>>> tb/tb_top.sv
// top of the orbit lagrange interpolator testbench: clock, reset, stimulus and verdict
// depends on olint_pkg, olint_checker and orbit_lagrange_interpolator
`timescale 1ns / 100ps
module tb_top;
   import olint_pkg::*;

   localparam longint SPACING = 64'd60 << FRAC_W;
   localparam int WATCHDOG_LIMIT = 250000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [4:0] csr_data = '0;
   int fail_count;
   int pending;
   int tx_idle = 0;
   int rx_idle = 0;
   bit hold_kick = 1'b0;
   int quiet_cycles = 0;
   int eff_count = 1;

   always #6 clock = ~clock;

   orbit_lagrange_interpolator dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   olint_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .fail_count(fail_count), .pending(pending)
   );

   // receiver stalls, plus one long hold-off on request
   always @(negedge clock) begin
      static int hold_left = 0;
      static bit hold_seen = 1'b0;
      if (hold_kick && !hold_seen) begin
         hold_left = 4000;
         hold_seen = 1'b1;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready = 1'b0;
      end else begin
         rsp_ready = ($urandom_range(99) >= rx_idle);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
         end
      end
   end

   function automatic logic [VAL_W-1:0] rand48();
      return VAL_W'({$urandom, $urandom});
   endfunction

   function automatic logic [VAL_W-1:0] rand_val();
      if ($urandom_range(99) < 85) return VAL_W'(signed'(rand48()) >>> 8);
      return rand48();
   endfunction

   task automatic send_item(req_type r);
      while ($urandom_range(99) < tx_idle) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data = r;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic settle();
      req_valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (50) @(negedge clock);
   endtask

   task automatic write_count(logic [4:0] v);
      settle();
      csr_valid = 1'b1;
      csr_data = v;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
      eff_count = (v == 0) ? 1 : (v > MAX_NODES) ? MAX_NODES : int'(v);
   endtask

   function automatic req_type make_load(int s, logic [VAL_W-1:0] t);
      req_type r;
      r.kind = KIND_LOAD;
      r.slot = 4'(s);
      r.sample_time = t;
      r.pos_x = rand_val(); r.pos_y = rand_val(); r.pos_z = rand_val();
      r.vel_x = rand_val(); r.vel_y = rand_val(); r.vel_z = rand_val();
      return r;
   endfunction

   function automatic req_type make_query(logic [VAL_W-1:0] t);
      req_type r;
      r = req_type'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom, $urandom});
      r.kind = KIND_QUERY;
      r.sample_time = t;
      return r;
   endfunction

   function automatic logic [VAL_W-1:0] in_span_time();
      return VAL_W'(longint'($urandom_range(0, eff_count * 60 * 1024)) * 1024 +
                    $urandom_range(1023));
   endfunction

   initial begin
      req_type r;
      int counts [9] = '{2, 3, 4, 1, 5, 2, 16, 3, 8};
      int max_q, n_q;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: fill the table, extremes on slot 0
      r = make_load(0, '0);
      r.pos_x = 48'sh7FFF_FFFF_FFFF; r.pos_y = 48'sh8000_0000_0000; r.pos_z = '0;
      r.vel_x = 48'sh8000_0000_0000; r.vel_y = 48'sh7FFF_FFFF_FFFF; r.vel_z = -48'sd1;
      send_item(r);
      for (int s = 1; s < MAX_NODES; s++) send_item(make_load(s, VAL_W'(s * SPACING)));
      // single node returns it unchanged
      send_item(make_query(48'sh7FFF_FFFF_FFFF));
      send_item(make_query(48'sh8000_0000_0000));
      write_count(5'd0);
      send_item(make_query(in_span_time()));
      // equal node times, weight and result overflow
      write_count(5'd3);
      send_item(make_load(2, VAL_W'(SPACING)));
      send_item(make_query(VAL_W'(SPACING / 2)));
      send_item(make_query(48'sh7FFF_FFFF_FFFF));
      write_count(5'd31);
      send_item(make_query(in_span_time()));

      for (int p = 0; p < 9; p++) begin
         write_count(5'(counts[p]));
         tx_idle = (p < 3) ? 18 : (p < 6) ? 62 : 0;
         rx_idle = (p < 3) ? 62 : (p < 6) ? 18 : 0;
         max_q = (eff_count >= 16) ? 2 : (eff_count >= 8) ? 5 : 40;
         n_q = 0;
         if (p == 1) begin
            // long receiver hold-off while queries keep coming
            hold_kick = 1'b1;
            for (int k = 0; k < 4; k++) send_item(make_query(in_span_time()));
            n_q = 4;
         end
         for (int k = 0; k < 64; k++) begin
            if (n_q < max_q && $urandom_range(99) < 45) begin
               n_q++;
               send_item(make_query(($urandom_range(99) < 85) ? in_span_time() : rand48()));
            end else if ($urandom_range(99) < 85) begin
               int s;
               s = $urandom_range(MAX_NODES - 1);
               send_item(make_load(s, VAL_W'(s * SPACING + $urandom_range(0, 1 << 22))));
            end else begin
               send_item(req_type'({$urandom, $urandom, $urandom, $urandom, $urandom,
                                    $urandom, $urandom, $urandom, $urandom, $urandom,
                                    $urandom}) & ~(req_type'(1) << ($bits(req_type) - 1)));
            end
         end
      end

      settle();
      repeat (100) @(negedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule
